/* rtl/core/bstl_pkg.sv */
// ----------------------------------------------------------------------------
// bstl_pkg
// Shared types and constants for the sorted top list: entry layout, field
// widths and the insert word handed down the row of cells.
// ----------------------------------------------------------------------------
package bstl_pkg;

  localparam int unsigned TAG_W       = 24;
  localparam int unsigned SCORE_W     = 32;
  localparam int unsigned INDEX_W     = 3;
  localparam int unsigned RANK_W      = 3;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned READ_SLOTS  = 1 << INDEX_W;
  localparam int unsigned DEPTH_DEF   = 8;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_READ   = 1'b1
  } action_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // word broadcast to every cell for an insert
  typedef struct packed {
    logic   en;
    entry_t ent;
  } ins_t;

  // a tag is a short string: everything after the first zero byte is zero
  function automatic logic [TAG_W-1:0] clean_tag(input logic [TAG_W-1:0] t);
    logic [TAG_W-1:0] r;
    r = t;
    if (t[23:16] == 8'd0) begin
      r = '0;
    end else if (t[15:8] == 8'd0) begin
      r = {t[23:16], 16'd0};
    end
    return r;
  endfunction

endpackage

/* rtl/core/bstl_cell.sv */
// ----------------------------------------------------------------------------
// bstl_cell
// One list position. Compares the broadcast score with its own entry and,
// on an insert, keeps its entry, takes the new one, or takes its upper
// neighbor's entry.
// ----------------------------------------------------------------------------
module bstl_cell (
  input  logic            clk,
  input  bstl_pkg::ins_t  ins,
  input  logic            valid,
  input  logic            prev_ge,
  input  bstl_pkg::entry_t prev_ent,
  output logic            ge,
  output logic            take_new,
  output bstl_pkg::entry_t ent
);
  import bstl_pkg::*;

  entry_t ent_next;

  // entry stays in place when it outranks or ties the new score
  assign ge       = valid && ($signed(ent.score) >= $signed(ins.ent.score));
  assign take_new = !ge && prev_ge;

  always_comb begin
    ent_next = ent;
    if (ins.en && !ge) begin
      if (prev_ge) begin
        ent_next = ins.ent;
      end else begin
        ent_next = prev_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

/* rtl/core/bounded_sorted_top_list_top.sv */
// ----------------------------------------------------------------------------
// bounded_sorted_top_list_top
// Top-k list of tagged signed scores kept in descending order.
// ----------------------------------------------------------------------------
// One command per clock: busy stays low, every start is taken, and its result
// appears on the following cycle with done high for exactly one cycle; the
// receiver cannot stall it, so capture it then. An insert needs no search because
// every cell of the row compares its score with the new one in parallel and
// shifts toward its lower neighbor in the same edge; a read selects one of the
// first eight cells. Equal scores keep arrival order.
// ----------------------------------------------------------------------------
module bounded_sorted_top_list_top #(
  parameter int unsigned LIST_DEPTH = bstl_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             action,
  input  logic signed [bstl_pkg::SCORE_W-1:0] new_score,
  input  logic [bstl_pkg::TAG_W-1:0]       new_tag,
  input  logic [bstl_pkg::INDEX_W-1:0]     read_index,
  output logic                             done,
  output logic                             accepted,
  output logic [bstl_pkg::RANK_W-1:0]      rank,
  output logic                             entry_valid,
  output logic [bstl_pkg::TAG_W-1:0]       entry_tag,
  output logic signed [bstl_pkg::SCORE_W-1:0] entry_score,
  output logic [bstl_pkg::COUNT_W-1:0]     entry_count
);
  import bstl_pkg::*;

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic           go;
  logic           is_insert;
  logic           full;
  logic           insert_go;
  ins_t           ins;
  entry_t         cell_ent  [LIST_DEPTH];
  logic           cell_ge   [LIST_DEPTH];
  logic           cell_take [LIST_DEPTH];
  logic           cell_valid[LIST_DEPTH];
  entry_t         rd_slots  [READ_SLOTS];
  entry_t         rd_ent;
  logic           rd_hit;
  logic [PW-1:0]  pos;

  assign busy      = 1'b0;
  assign go        = start && !busy;
  assign is_insert = (action_t'(action) == ACT_INSERT);
  assign full      = (count == CW'(LIST_DEPTH));
  assign insert_go = go && is_insert &&
                     !(full && ($signed(new_score) <=
                                $signed(cell_ent[LIST_DEPTH-1].score)));

  assign ins.en        = insert_go;
  assign ins.ent.tag   = clean_tag(new_tag);
  assign ins.ent.score = new_score;

  // row of cells, each fed by its upper neighbor
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    assign cell_valid[i] = (CW'(i) < count);
    if (i == 0) begin : g_head
      bstl_cell u_cell (
        .clk      (clk),
        .ins      (ins),
        .valid    (cell_valid[i]),
        .prev_ge  (1'b1),
        .prev_ent (ins.ent),
        .ge       (cell_ge[i]),
        .take_new (cell_take[i]),
        .ent      (cell_ent[i])
      );
    end else begin : g_body
      bstl_cell u_cell (
        .clk      (clk),
        .ins      (ins),
        .valid    (cell_valid[i]),
        .prev_ge  (cell_ge[i-1]),
        .prev_ent (cell_ent[i-1]),
        .ge       (cell_ge[i]),
        .take_new (cell_take[i]),
        .ent      (cell_ent[i])
      );
    end
  end

  // encode the one cell that takes the new entry
  always_comb begin
    pos = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (cell_take[i]) begin
        pos = pos | PW'(i);
      end
    end
  end

  for (genvar k = 0; k < READ_SLOTS; k++) begin : g_rd
    if (k < LIST_DEPTH) begin : g_live
      assign rd_slots[k] = cell_ent[k];
    end else begin : g_none
      assign rd_slots[k] = '0;
    end
  end

  assign rd_ent = rd_slots[read_index];
  assign rd_hit = ({{CW{1'b0}}, read_index} < {{INDEX_W{1'b0}}, count}) &&
                  (32'(read_index) < 32'(LIST_DEPTH));

  always_comb begin
    count_next = count;
    if (insert_go && !full) begin
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= go;
    end
  end

  // result word, registered on each command and held until the next one
  always_ff @(posedge clk) begin
    if (go) begin
      accepted    <= insert_go;
      rank        <= insert_go ? RANK_W'(pos) : '0;
      entry_valid <= !is_insert && rd_hit;
      entry_tag   <= (!is_insert && rd_hit) ? rd_ent.tag : '0;
      entry_score <= (!is_insert && rd_hit) ? rd_ent.score : '0;
      entry_count <= COUNT_W'(count_next);
    end
  end

endmodule
